>>> design/assert_macros.svh
// Assertion macros shared by the decimal literal scanner modules.
// Every macro expects a clock named clk and an active-low reset named rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`else
`define ASSERT_IMPLY(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, cond, msg)
`endif
`endif

>>> design/dnls_pkg.sv
// Types and constants for the decimal literal scanner.
// No dependencies; every module of the block imports this package.
package dnls_pkg;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_SPACE,
    PH_SIGN,
    PH_INT,
    PH_DOT,
    PH_FRAC,
    PH_EXP,
    PH_EXPSIGN,
    PH_EXPDIG
  } phase_t;

  typedef enum logic [2:0] {
    CC_SPACE,
    CC_DIGIT,
    CC_DOT,
    CC_MINUS,
    CC_PLUS,
    CC_EXP,
    CC_OTHER
  } char_class_t;

  typedef enum logic [1:0] {
    ST_ACCEPT = 2'd0,
    ST_REJECT = 2'd1,
    ST_LONG   = 2'd2
  } status_t;

  typedef struct packed {
    logic       valid;
    status_t    status;
    logic [7:0] skipped;
    logic [7:0] end_offset;
  } result_t;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_LOW_E = 8'h65;
  localparam logic [7:0] CH_UP_E  = 8'h45;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

endpackage

>>> design/dnls_class.sv
// Character classifier: sorts one text byte into the classes the scanner uses.
// Depends on dnls_pkg.
module dnls_class (
  input  logic [7:0]               ch,
  output dnls_pkg::char_class_t    cls
);
  import dnls_pkg::*;

  always_comb begin
    if (ch == CH_SP || ch == CH_TAB || ch == CH_LF || ch == CH_CR) begin
      cls = CC_SPACE;
    end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
      cls = CC_DIGIT;
    end else if (ch == CH_DOT) begin
      cls = CC_DOT;
    end else if (ch == CH_MINUS) begin
      cls = CC_MINUS;
    end else if (ch == CH_PLUS) begin
      cls = CC_PLUS;
    end else if (ch == CH_LOW_E || ch == CH_UP_E) begin
      cls = CC_EXP;
    end else begin
      cls = CC_OTHER;
    end
  end

endmodule

>>> design/dnls_step.sv
// Scan state machine: phase register, byte and whitespace counters, and the
// result decision for one character. Depends on dnls_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dnls_step #(
  parameter int MAX_LEN = 255
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  first,
  input  dnls_pkg::char_class_t cls,
  output dnls_pkg::result_t     res
);
  import dnls_pkg::*;

  localparam int CNT_W = $clog2(MAX_LEN + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LEN);
  localparam logic [7:0] MAX_SAT = (MAX_LEN > 255) ? 8'd255 : 8'(MAX_LEN);

  phase_t           phase_r, phase_nxt;
  logic [CNT_W-1:0] char_cnt_r, char_cnt_nxt;
  logic [CNT_W-1:0] space_cnt_r, space_cnt_nxt;

  phase_t           cur_phase;
  logic [CNT_W-1:0] cur_char;
  logic [CNT_W-1:0] cur_space;
  phase_t           step_phase;
  logic             go_accept;
  logic             go_reject;

  function automatic logic [7:0] sat8(input logic [CNT_W-1:0] v);
    if (32'(v) > 32'd255) begin
      return 8'd255;
    end
    return 8'(v);
  endfunction

  // A start flag reopens the scan before this byte is looked at.
  assign cur_phase = first ? PH_SPACE : phase_r;
  assign cur_char  = first ? '0 : char_cnt_r;
  assign cur_space = first ? '0 : space_cnt_r;

  always_comb begin
    step_phase = PH_IDLE;
    go_accept  = 1'b0;
    go_reject  = 1'b0;
    case (cur_phase)
      PH_SPACE: begin
        case (cls)
          CC_SPACE: step_phase = PH_SPACE;
          CC_MINUS: step_phase = PH_SIGN;
          CC_DIGIT: step_phase = PH_INT;
          CC_DOT:   step_phase = PH_DOT;
          default:  go_reject  = 1'b1;
        endcase
      end
      PH_SIGN: begin
        case (cls)
          CC_DIGIT: step_phase = PH_INT;
          CC_DOT:   step_phase = PH_DOT;
          default:  go_reject  = 1'b1;
        endcase
      end
      PH_INT: begin
        case (cls)
          CC_DIGIT: step_phase = PH_INT;
          CC_DOT:   step_phase = PH_FRAC;
          CC_EXP:   step_phase = PH_EXP;
          default:  go_accept  = 1'b1;
        endcase
      end
      PH_DOT: begin
        case (cls)
          CC_DIGIT: step_phase = PH_FRAC;
          default:  go_reject  = 1'b1;
        endcase
      end
      PH_FRAC: begin
        case (cls)
          CC_DIGIT: step_phase = PH_FRAC;
          CC_EXP:   step_phase = PH_EXP;
          default:  go_accept  = 1'b1;
        endcase
      end
      PH_EXP: begin
        case (cls)
          CC_PLUS, CC_MINUS: step_phase = PH_EXPSIGN;
          CC_DIGIT:          step_phase = PH_EXPDIG;
          default:           go_reject  = 1'b1;
        endcase
      end
      PH_EXPSIGN: begin
        case (cls)
          CC_DIGIT: step_phase = PH_EXPDIG;
          default:  go_reject  = 1'b1;
        endcase
      end
      PH_EXPDIG: begin
        case (cls)
          CC_DIGIT: step_phase = PH_EXPDIG;
          default:  go_accept  = 1'b1;
        endcase
      end
      default: begin
        step_phase = PH_IDLE;
      end
    endcase
  end

  always_comb begin
    phase_nxt      = cur_phase;
    char_cnt_nxt   = cur_char;
    space_cnt_nxt  = cur_space;
    res.valid      = 1'b0;
    res.status     = ST_ACCEPT;
    res.skipped    = sat8(cur_space);
    res.end_offset = sat8(cur_char);
    if (cur_phase != PH_IDLE) begin
      if (go_accept || go_reject) begin
        res.valid  = 1'b1;
        res.status = go_accept ? ST_ACCEPT : ST_REJECT;
        phase_nxt  = PH_IDLE;
      end else if (cur_char >= MAX_CNT) begin
        // The byte would still extend the literal but the length budget is spent.
        res.valid      = 1'b1;
        res.status     = ST_LONG;
        res.end_offset = MAX_SAT;
        phase_nxt      = PH_IDLE;
      end else begin
        if (step_phase == PH_SPACE) begin
          space_cnt_nxt = cur_space + 1'b1;
        end
        char_cnt_nxt = cur_char + 1'b1;
        phase_nxt    = step_phase;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      char_cnt_r  <= '0;
      space_cnt_r <= '0;
    end else if (en) begin
      phase_r     <= phase_nxt;
      char_cnt_r  <= char_cnt_nxt;
      space_cnt_r <= space_cnt_nxt;
    end
  end

  `ASSERT_ALWAYS(a_space_le_char, space_cnt_r <= char_cnt_r, "whitespace count exceeds byte count")
  `ASSERT_ALWAYS(a_char_le_max, char_cnt_r <= MAX_CNT, "byte count ran past the length limit")
  `ASSERT_IMPLY(a_result_closes, en && res.valid |=> phase_r == PH_IDLE, "scan still open after its result")
  `ASSERT_IMPLY(a_idle_no_result, en && !first && phase_r == PH_IDLE |-> !res.valid, "result with no scan open")

endmodule

>>> design/decimal_number_literal_scanner.sv
// Decimal literal scanner, top level. An item sits in the input register, and its result
// (if any) is then loaded into the result register, held back while that slot is full
// and not being drained. Throughput: one item per cycle while the result slot is free.
// Reset (rst_n low, synchronous) empties both registers and puts the scan idle.
// Depends on dnls_pkg, dnls_class, dnls_step and assert_macros.svh.
`include "assert_macros.svh"

module decimal_number_literal_scanner #(
  parameter int MAX_LEN = 255
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  input  logic        in_tuser,   // [0] first
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [1:0] status, [9:2] skipped, [17:10] end_offset, zero pad
);
  import dnls_pkg::*;

  logic        in_valid_r;
  logic        in_first_r;
  logic [7:0]  in_ch_r;
  logic        out_valid_r;
  logic [17:0] out_data_r;

  logic        out_free;
  logic        proc;
  char_class_t cls;
  result_t     res;
  logic [1:0]  out_status;
  logic [7:0]  out_skipped;
  logic [7:0]  out_end;

  // The result slot can take a new value when empty or being drained this cycle.
  assign out_free  = !out_valid_r || out_tready;
  assign proc      = in_valid_r && out_free;
  assign in_tready = !in_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_first_r <= in_tuser;
      in_ch_r    <= in_tdata;
    end
  end

  dnls_class u_class (
    .ch  (in_ch_r),
    .cls (cls)
  );

  dnls_step #(
    .MAX_LEN (MAX_LEN)
  ) u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (proc),
    .first (in_first_r),
    .cls   (cls),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= proc && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && res.valid) begin
      out_data_r <= {res.end_offset, res.skipped, res.status};
    end
  end

  assign {out_end, out_skipped, out_status} = out_data_r;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_end, out_skipped, out_status};

  `ASSERT_IMPLY(a_status_legal, out_tvalid |-> out_status <= ST_LONG, "illegal status code")
  `ASSERT_IMPLY(a_skip_le_end, out_tvalid |-> out_skipped <= out_end, "skip past end offset")
  `ASSERT_IMPLY(a_no_drop, in_valid_r && !proc |=> in_valid_r && $stable(in_ch_r), "item lost")

endmodule

>>> tb/tb_decimal_number_literal_scanner.sv
// Self-checking testbench for decimal_number_literal_scanner: a directed table, then random
// literal scans under four idling patterns, checked against a local scan predictor.
// Depends on dnls_pkg and the scanner RTL.
`timescale 1ns / 100ps

module tb_decimal_number_literal_scanner;
  import dnls_pkg::*;

  localparam int SCAN_MAX        = 255;
  localparam int ITEMS_PER_PHASE = 400;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_TOP   = 8'hFF;

  typedef struct packed {
    status_t    st;
    logic [7:0] skipped;
    logic [7:0] end_off;
  } scan_result_t;

  typedef struct packed {
    logic       first;
    logic [7:0] ch;
  } char_item_t;

  typedef struct packed {
    logic       first;
    logic [7:0] ch;
    logic       typed;
    status_t    st;
    logic [7:0] sk;
    logic [7:0] off;
  } directed_row_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        in_tuser   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;

  // Predictor state.
  phase_t      lit_phase  = PH_IDLE;
  int unsigned lit_chars  = 0;
  int unsigned lit_blanks = 0;

  scan_result_t expected_scans[$];
  char_item_t   scan_bytes[$];
  int           mismatches    = 0;
  int           live_items    = 0;
  int           send_idle_pct = 0;
  int           stall_pct     = 0;

  // Rows with typed=1 carry the result that their item must end with.
  directed_row_t directed_rows[31] = '{
    '{1'b0, CH_X,           1'b0, ST_ACCEPT, 8'd0, 8'd0},
    '{1'b0, CH_TOP,         1'b0, ST_ACCEPT, 8'd0, 8'd0},
    '{1'b1, CH_ZERO + 8'd5, 1'b0, ST_ACCEPT, 8'd0, 8'd0},
    '{1'b0, CH_NUL,         1'b1, ST_ACCEPT, 8'd0, 8'd1},
    '{1'b1, CH_SP,          1'b0, ST_ACCEPT, 8'd0, 8'd0},
    '{1'b0, CH_TAB,         1'b0, ST_ACCEPT, 8'd0, 8'd0},
    '{1'b0, CH_LF,          1'b0, ST_ACCEPT, 8'd0, 8'd0},
    '{1'b0, CH_CR,          1'b0, ST_ACCEPT, 8'd0, 8'd0},
    '{1'b0, CH_MINUS,       1'b0, ST_ACCEPT, 8'd0, 8'd0},
    '{1'b0, CH_ZERO + 8'd1, 1'b0, ST_ACCEPT, 8'd0, 8'd0},
    '{1'b0, CH_DOT,         1'b0, ST_ACCEPT, 8'd0, 8'd0},
    '{1'b0, CH_ZERO + 8'd2, 1'b0, ST_ACCEPT, 8'd0, 8'd0},
    '{1'b0, CH_UP_E,        1'b0, ST_ACCEPT, 8'd0, 8'd0},
    '{1'b0, CH_PLUS,        1'b0, ST_ACCEPT, 8'd0, 8'd0},
    '{1'b0, CH_ZERO + 8'd7, 1'b0, ST_ACCEPT, 8'd0, 8'd0},
    '{1'b0, CH_TOP,         1'b1, ST_ACCEPT, 8'd4, 8'd11},
    '{1'b1, CH_ZERO,        1'b0, ST_ACCEPT, 8'd0, 8'd0},
    '{1'b0, CH_LOW_E,       1'b0, ST_ACCEPT, 8'd0, 8'd0},
    '{1'b0, CH_SP,          1'b1, ST_REJECT, 8'd0, 8'd2},
    '{1'b1, CH_MINUS,       1'b0, ST_ACCEPT, 8'd0, 8'd0},
    '{1'b0, CH_LOW_E,       1'b1, ST_REJECT, 8'd0, 8'd1},
    '{1'b1, CH_DOT,         1'b0, ST_ACCEPT, 8'd0, 8'd0},
    '{1'b0, CH_DOT,         1'b1, ST_REJECT, 8'd0, 8'd1},
    '{1'b1, CH_ZERO + 8'd7, 1'b0, ST_ACCEPT, 8'd0, 8'd0},
    '{1'b1, CH_DOT,         1'b0, ST_ACCEPT, 8'd0, 8'd0},
    '{1'b0, CH_NINE,        1'b0, ST_ACCEPT, 8'd0, 8'd0},
    '{1'b0, CH_UP_E,        1'b0, ST_ACCEPT, 8'd0, 8'd0},
    '{1'b0, CH_MINUS,       1'b0, ST_ACCEPT, 8'd0, 8'd0},
    '{1'b0, CH_X,           1'b1, ST_REJECT, 8'd0, 8'd4},
    '{1'b0, CH_NINE,        1'b0, ST_ACCEPT, 8'd0, 8'd0},
    '{1'b1, CH_TOP,         1'b1, ST_REJECT, 8'd0, 8'd0}
  };

  decimal_number_literal_scanner #(.MAX_LEN(SCAN_MAX)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic bit is_dec_digit(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == CH_SP || c == CH_TAB || c == CH_LF || c == CH_CR;
  endfunction

  function automatic logic [7:0] sat8(int unsigned v);
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  // PH_IDLE as the next phase means the byte ends the scan; ok tells accept from reject.
  function automatic phase_t next_lit_phase(phase_t ph, logic [7:0] c, output bit ok);
    phase_t nx;
    bit     is_e;
    nx   = PH_IDLE;
    ok   = 1'b0;
    is_e = (c == CH_LOW_E || c == CH_UP_E);
    case (ph)
      PH_SPACE: begin
        if (is_blank(c)) nx = PH_SPACE;
        else if (c == CH_MINUS) nx = PH_SIGN;
        else if (is_dec_digit(c)) nx = PH_INT;
        else if (c == CH_DOT) nx = PH_DOT;
      end
      PH_SIGN: begin
        if (is_dec_digit(c)) nx = PH_INT;
        else if (c == CH_DOT) nx = PH_DOT;
      end
      PH_INT: begin
        if (is_dec_digit(c)) nx = PH_INT;
        else if (c == CH_DOT) nx = PH_FRAC;
        else if (is_e) nx = PH_EXP;
        else ok = 1'b1;
      end
      PH_DOT: begin
        if (is_dec_digit(c)) nx = PH_FRAC;
      end
      PH_FRAC: begin
        if (is_dec_digit(c)) nx = PH_FRAC;
        else if (is_e) nx = PH_EXP;
        else ok = 1'b1;
      end
      PH_EXP: begin
        if (c == CH_PLUS || c == CH_MINUS) nx = PH_EXPSIGN;
        else if (is_dec_digit(c)) nx = PH_EXPDIG;
      end
      PH_EXPSIGN: begin
        if (is_dec_digit(c)) nx = PH_EXPDIG;
      end
      PH_EXPDIG: begin
        if (is_dec_digit(c)) nx = PH_EXPDIG;
        else ok = 1'b1;
      end
      default: ;
    endcase
    return nx;
  endfunction

  function automatic void scan_literal_char(input logic f, input logic [7:0] c,
                                            output bit live, output bit done,
                                            output scan_result_t res);
    phase_t nx;
    bit     ok;
    done = 1'b0;
    res  = '{ST_ACCEPT, 8'd0, 8'd0};
    if (f) begin
      lit_phase  = PH_SPACE;
      lit_chars  = 0;
      lit_blanks = 0;
    end
    live = (lit_phase != PH_IDLE);
    if (!live) return;
    nx = next_lit_phase(lit_phase, c, ok);
    if (nx == PH_IDLE || lit_chars >= SCAN_MAX) begin
      done        = 1'b1;
      res.st      = (nx != PH_IDLE) ? ST_LONG : (ok ? ST_ACCEPT : ST_REJECT);
      res.skipped = sat8(lit_blanks);
      res.end_off = (nx != PH_IDLE) ? sat8(SCAN_MAX) : sat8(lit_chars);
      lit_phase   = PH_IDLE;
    end else begin
      if (nx == PH_SPACE) lit_blanks++;
      lit_chars++;
      lit_phase = nx;
    end
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    scan_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_scans.size() == 0) begin
        $display("%0t: result with nothing expected, got %h", $time, out_tdata);
        mismatches++;
      end else begin
        want = expected_scans.pop_front();
        check_field("status", want.st, out_tdata[1:0]);
        check_field("skipped", want.skipped, out_tdata[9:2]);
        check_field("end_offset", want.end_off, out_tdata[17:10]);
        check_field("pad", 0, out_tdata[23:18]);
      end
    end
  end

  // Entered and left at a falling edge; valid stays high between back-to-back items.
  task automatic send_char(input logic f, input logic [7:0] c, input bit typed,
                           input scan_result_t typed_res);
    bit           live, done;
    scan_result_t res;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= f;
    in_tdata  <= c;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    scan_literal_char(f, c, live, done, res);
    if (live) live_items++;
    if (typed) expected_scans.push_back(typed_res);
    else if (done) expected_scans.push_back(res);
    @(negedge clk);
  endtask

  function automatic void add_char(input logic [7:0] c);
    char_item_t it;
    it.first = (scan_bytes.size() == 0);
    it.ch    = c;
    scan_bytes.push_back(it);
  endfunction

  function automatic logic [7:0] rand_blank();
    case ($urandom_range(3))
      0: return CH_SP;
      1: return CH_TAB;
      2: return CH_LF;
      default: return CH_CR;
    endcase
  endfunction

  function automatic logic [7:0] rand_digit();
    return CH_ZERO + 8'($urandom_range(9));
  endfunction

  function automatic logic [7:0] rand_exp_letter();
    return $urandom_range(1) ? CH_LOW_E : CH_UP_E;
  endfunction

  function automatic logic [7:0] rand_end();
    case ($urandom_range(4))
      0: return CH_NUL;
      1: return CH_SP;
      2: return CH_TOP;
      3: return CH_COMMA;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // A well-formed literal without its terminating byte.
  function automatic void add_literal();
    int n, n_int;
    n = ($urandom_range(2) == 0) ? $urandom_range(3, 1) : 0;
    repeat (n) add_char(rand_blank());
    if ($urandom_range(2) == 0) add_char(CH_MINUS);
    n_int = $urandom_range(4);
    repeat (n_int) add_char(rand_digit());
    if (n_int == 0 || $urandom_range(1)) begin
      add_char(CH_DOT);
      n = $urandom_range(3, (n_int == 0) ? 1 : 0);
      repeat (n) add_char(rand_digit());
    end
    if ($urandom_range(4) < 2) begin
      add_char(rand_exp_letter());
      case ($urandom_range(2))
        0: add_char(CH_PLUS);
        1: add_char(CH_MINUS);
        default: ;
      endcase
      n = $urandom_range(3, 1);
      repeat (n) add_char(rand_digit());
    end
  endfunction

  // The first scan of each phase is a long run: past the length limit in even phases,
  // ending at or just below it in odd ones. The kind of run follows the phase number.
  function automatic void build_scan(input int k, input int p);
    int         kind, n, target, idx;
    char_item_t it;
    scan_bytes.delete();
    kind = (k == 0) ? 100 : $urandom_range(99);
    if (kind == 100) begin
      target = (p % 2 == 0) ? $urandom_range(260, 256) : $urandom_range(255, 250);
      if (p == 1 && $urandom_range(1)) add_char(CH_MINUS);
      if (p >= 2) add_char(rand_digit());
      if (p == 2) add_char(CH_DOT);
      if (p == 3) add_char(rand_exp_letter());
      while (scan_bytes.size() < target) add_char((p == 0) ? rand_blank() : rand_digit());
      add_char((p % 2 == 0) ? rand_end() : CH_COMMA);
    end else if (kind < 60) begin
      add_literal();
      add_char(rand_end());
    end else if (kind < 80) begin
      case (kind % 4)
        0: begin
          add_literal();
          add_char(rand_exp_letter());
          if ($urandom_range(1)) add_char($urandom_range(1) ? CH_PLUS : CH_MINUS);
          add_char(rand_end());
        end
        1: begin
          n = $urandom_range(2);
          repeat (n) add_char(rand_blank());
          if ($urandom_range(1)) add_char(CH_MINUS);
          if ($urandom_range(1)) add_char(CH_DOT);
          add_char(rand_end());
        end
        2: begin
          add_literal();
          add_char(rand_end());
          idx = $urandom_range(scan_bytes.size() - 1);
          case ($urandom_range(4))
            0: scan_bytes[idx].ch = CH_DOT;
            1: scan_bytes[idx].ch = rand_exp_letter();
            2: scan_bytes[idx].ch = CH_PLUS;
            3: scan_bytes[idx].ch = CH_MINUS;
            default: scan_bytes[idx].ch = 8'($urandom_range(255));
          endcase
        end
        default: add_literal();  // left open; the next start abandons it
      endcase
    end else begin
      n = $urandom_range(6, 1);
      repeat (n) begin
        it.first = ($urandom_range(3) == 0);
        it.ch    = 8'($urandom_range(255));
        scan_bytes.push_back(it);
      end
    end
  endfunction

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_char(directed_rows[i].first, directed_rows[i].ch, directed_rows[i].typed,
                scan_result_t'{directed_rows[i].st, directed_rows[i].sk,
                               directed_rows[i].off});
    end

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 77;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 77;
        end
        default: begin
          send_idle_pct = 27;
          stall_pct     = 27;
        end
      endcase
      live_items = 0;
      for (int k = 0; live_items < ITEMS_PER_PHASE; k++) begin
        build_scan(k, p);
        foreach (scan_bytes[i]) send_char(scan_bytes[i].first, scan_bytes[i].ch, 1'b0, '0);
      end
    end
    in_tvalid <= 1'b0;

    for (int w = 0; w < 4000 && expected_scans.size() != 0; w++) @(posedge clk);
    if (expected_scans.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_scans.size());
      mismatches++;
    end
    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
